// ----- sv/limit_switch_supervisor_assert.svh -----
// assertion macros for the limit switch supervisor
`ifndef LIMIT_SWITCH_SUPERVISOR_ASSERT_SVH
`define LIMIT_SWITCH_SUPERVISOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("limit switch supervisor check failed");

// next-cycle implication, checked outside reset
`define LSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("limit switch supervisor check failed");

`endif

// ----- sv/lss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_pkg
// types and constants shared by the limit switch supervisor files
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int POSITION_WIDTH_DEF   = 32;
    localparam int TICK_COUNT_WIDTH_DEF = 16;

    localparam int SEL_W    = 2;
    localparam int OFFSET_W = 31;
    localparam int HOLD_W   = 16;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [SEL_W-1:0]    POS_SEL_RST   = SEL_W'(1);
    localparam logic [SEL_W-1:0]    NEG_SEL_RST   = SEL_W'(2);
    localparam logic [OFFSET_W-1:0] OFFSET_RST    = OFFSET_W'(1000);
    localparam logic [OFFSET_W-1:0] DEADZONE_RST  = OFFSET_W'(100);
    localparam logic [HOLD_W-1:0]   HOLD_RST      = HOLD_W'(50 * 10);

    localparam logic [SEL_W-1:0]    SEL_SWITCH_ONE = SEL_W'(1);
    localparam logic [SEL_W-1:0]    SEL_SWITCH_TWO = SEL_W'(2);

    typedef enum logic [2:0] {
        REG_POS_SEL  = 3'd0,
        REG_NEG_SEL  = 3'd1,
        REG_OFFSET   = 3'd2,
        REG_DEADZONE = 3'd3,
        REG_HOLD     = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        FK_NONE = 2'd0,
        FK_SW1  = 2'd1,
        FK_SW2  = 2'd2,
        FK_BOTH = 2'd3
    } fault_kind_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_POS  = 2'd1,
        DIR_NEG  = 2'd2
    } dir_t;

endpackage

// ----- sv/lss_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_if
// request channels of the limit switch supervisor: sample in, status out
// ----------------------------------------------------------------------------
interface lss_in_if
    import lss_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
);
    logic                             valid;
    logic                             ready;
    logic                             sw1_open_contact;
    logic                             sw1_closed_contact;
    logic                             sw2_open_contact;
    logic                             sw2_closed_contact;
    logic signed [POSITION_WIDTH-1:0] axis_position;

    modport source (
        output valid, sw1_open_contact, sw1_closed_contact,
               sw2_open_contact, sw2_closed_contact, axis_position,
        input  ready
    );

    modport sink (
        input  valid, sw1_open_contact, sw1_closed_contact,
               sw2_open_contact, sw2_closed_contact, axis_position,
        output ready
    );
endinterface

interface lss_out_if
    import lss_pkg::*;
;
    logic        valid;
    logic        ready;
    logic        fault_active;
    fault_kind_t fault_kind;
    dir_t        active_dir;
    logic        limit_reached;

    modport source (
        output valid, fault_active, fault_kind, active_dir, limit_reached,
        input  ready
    );

    modport sink (
        input  valid, fault_active, fault_kind, active_dir, limit_reached,
        output ready
    );
endinterface

// ----- sv/limit_switch_supervisor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_switch_supervisor
// Supervises two limit switches: sensor fault qualification, overtravel
// detection past switch entry and direction release after back-out.
//
// Use: one sample request per tick on the sample channel (four contact levels
// and the axis position), one status request per sample on the result channel.
// The user must write settings over the APB port only while no sample is in
// flight; the block itself does not enforce this. A sample is registered in the
// sample register, then through the single update pass in the state/status
// registers, which raises result valid. Throughput: one sample per cycle while
// the result is taken. The status registers are the supervisor state itself, so
// a stalled result holds the state; one more sample is taken into the sample
// register and waits there until the result is taken.
// Reset: rst_n clears both channels, the fault counter, flags, direction and
// base position, and loads the setting defaults (positive on switch one,
// negative on switch two, offset 1000, deadzone 100, hold 500 ticks).
// ----------------------------------------------------------------------------
`include "limit_switch_supervisor_assert.svh"

module limit_switch_supervisor
    import lss_pkg::*;
#(
    parameter int POSITION_WIDTH   = POSITION_WIDTH_DEF,
    parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    lss_in_if.sink            sample,
    lss_out_if.source         result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int DW     = POSITION_WIDTH + 1;
    localparam int CW     = (DW > OFFSET_W + 1) ? DW : OFFSET_W + 1;
    localparam int CMP_W  = (TICK_COUNT_WIDTH > HOLD_W) ? TICK_COUNT_WIDTH : HOLD_W;
    localparam logic [TICK_COUNT_WIDTH-1:0] TICK_MAX = '1;

    // settings
    logic [SEL_W-1:0]    pos_sel_reg;
    logic [SEL_W-1:0]    neg_sel_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [OFFSET_W-1:0] deadzone_reg;
    logic [HOLD_W-1:0]   hold_reg;

    cfg_index_t cfg_index;
    logic       cfg_write;

    // sample register
    logic                             in_valid_reg;
    logic                             no1_reg;
    logic                             nc1_reg;
    logic                             no2_reg;
    logic                             nc2_reg;
    logic signed [POSITION_WIDTH-1:0] pos_reg;

    // state, also the status register
    logic                             out_valid_reg;
    logic [TICK_COUNT_WIDTH-1:0]      fault_ticks_reg;
    logic [TICK_COUNT_WIDTH-1:0]      fault_ticks_next;
    logic                             fault_flag_reg;
    logic                             fault_flag_next;
    fault_kind_t                      fault_code_reg;
    fault_kind_t                      fault_code_next;
    dir_t                             direction_reg;
    dir_t                             direction_next;
    logic                             reached_flag_reg;
    logic                             reached_flag_next;
    logic signed [POSITION_WIDTH-1:0] base_position_reg;
    logic signed [POSITION_WIDTH-1:0] base_position_next;

    logic                        advance;
    logic                        take;
    fault_kind_t                 kind;
    logic [TICK_COUNT_WIDTH-1:0] ticks_inc;
    logic [CMP_W-1:0]            ticks_cmp;
    logic [CMP_W-1:0]            hold_cmp;
    logic                        qualified;
    logic                        pos_no;
    logic                        neg_no;
    logic signed [DW-1:0]        pos_ext;
    logic signed [DW-1:0]        base_ext;
    logic signed [DW-1:0]        diff_up;
    logic signed [DW-1:0]        diff_dn;
    logic signed [CW-1:0]        up_cmp;
    logic signed [CW-1:0]        dn_cmp;
    logic signed [CW-1:0]        offs_cmp;
    logic signed [CW-1:0]        dz_cmp;

    // apb port
    assign pready    = 1'b1;
    assign cfg_index = cfg_index_t'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (cfg_index)
            REG_POS_SEL:  prdata = DATA_W'(pos_sel_reg);
            REG_NEG_SEL:  prdata = DATA_W'(neg_sel_reg);
            REG_OFFSET:   prdata = DATA_W'(offset_reg);
            REG_DEADZONE: prdata = DATA_W'(deadzone_reg);
            REG_HOLD:     prdata = DATA_W'(hold_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_sel_reg  <= POS_SEL_RST;
            neg_sel_reg  <= NEG_SEL_RST;
            offset_reg   <= OFFSET_RST;
            deadzone_reg <= DEADZONE_RST;
            hold_reg     <= HOLD_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_POS_SEL:  pos_sel_reg  <= pwdata[SEL_W-1:0];
                REG_NEG_SEL:  neg_sel_reg  <= pwdata[SEL_W-1:0];
                REG_OFFSET:   offset_reg   <= pwdata[OFFSET_W-1:0];
                REG_DEADZONE: deadzone_reg <= pwdata[OFFSET_W-1:0];
                REG_HOLD:     hold_reg     <= pwdata[HOLD_W-1:0];
                default:      ;
            endcase
        end
    end

    // handshake
    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;
    assign take         = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            no1_reg <= sample.sw1_open_contact;
            nc1_reg <= sample.sw1_closed_contact;
            no2_reg <= sample.sw2_open_contact;
            nc2_reg <= sample.sw2_closed_contact;
            pos_reg <= sample.axis_position;
        end
    end

    // fault qualification
    always_comb
    begin
        if (no1_reg == nc1_reg)
            kind = FK_SW1;
        else if (no2_reg == nc2_reg)
            kind = FK_SW2;
        else if (!no1_reg && !no2_reg)
            kind = FK_BOTH;
        else
            kind = FK_NONE;
    end

    assign ticks_inc = (fault_ticks_reg == TICK_MAX) ? fault_ticks_reg
                                                     : fault_ticks_reg + 1'b1;
    assign ticks_cmp = CMP_W'(ticks_inc);
    assign hold_cmp  = CMP_W'(hold_reg);
    assign qualified = (kind != FK_NONE) && (ticks_cmp >= hold_cmp);

    // overtravel arithmetic
    assign pos_no   = (pos_sel_reg == SEL_SWITCH_ONE) ? no1_reg : no2_reg;
    assign neg_no   = (neg_sel_reg == SEL_SWITCH_TWO) ? no2_reg : no1_reg;
    assign pos_ext  = DW'(pos_reg);
    assign base_ext = DW'(base_position_reg);
    assign diff_up  = pos_ext - base_ext;
    assign diff_dn  = base_ext - pos_ext;
    assign up_cmp   = CW'(diff_up);
    assign dn_cmp   = CW'(diff_dn);
    assign offs_cmp = signed'(CW'(offset_reg));
    assign dz_cmp   = signed'(CW'(deadzone_reg));

    always_comb
    begin
        fault_ticks_next   = fault_ticks_reg;
        fault_flag_next    = fault_flag_reg;
        fault_code_next    = fault_code_reg;
        direction_next     = direction_reg;
        reached_flag_next  = reached_flag_reg;
        base_position_next = base_position_reg;

        if (kind != FK_NONE)
        begin
            fault_ticks_next = ticks_inc;
            if (qualified)
            begin
                fault_flag_next = 1'b1;
                fault_code_next = kind;
            end
        end
        else
        begin
            fault_ticks_next = '0;
            fault_flag_next  = 1'b0;
            fault_code_next  = FK_NONE;
        end

        if (!qualified)
        begin
            if (!pos_no)
            begin
                if (direction_reg != DIR_POS)
                begin
                    direction_next     = DIR_POS;
                    base_position_next = pos_reg;
                    reached_flag_next  = 1'b0;
                end
                else
                    reached_flag_next = (up_cmp >= offs_cmp);
            end
            else if (!neg_no)
            begin
                if (direction_reg != DIR_NEG)
                begin
                    direction_next     = DIR_NEG;
                    base_position_next = pos_reg;
                    reached_flag_next  = 1'b0;
                end
                else
                    reached_flag_next = (dn_cmp >= offs_cmp);
            end
            else if (direction_reg == DIR_POS)
            begin
                if (dn_cmp >= dz_cmp)
                begin
                    direction_next    = DIR_NONE;
                    reached_flag_next = 1'b0;
                end
            end
            else if (direction_reg == DIR_NEG)
            begin
                if (up_cmp >= dz_cmp)
                begin
                    direction_next    = DIR_NONE;
                    reached_flag_next = 1'b0;
                end
            end
            else
            begin
                direction_next    = DIR_NONE;
                reached_flag_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_ticks_reg   <= '0;
            fault_flag_reg    <= 1'b0;
            fault_code_reg    <= FK_NONE;
            direction_reg     <= DIR_NONE;
            reached_flag_reg  <= 1'b0;
            base_position_reg <= '0;
        end
        else if (advance)
        begin
            fault_ticks_reg   <= fault_ticks_next;
            fault_flag_reg    <= fault_flag_next;
            fault_code_reg    <= fault_code_next;
            direction_reg     <= direction_next;
            reached_flag_reg  <= reached_flag_next;
            base_position_reg <= base_position_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.fault_active  = fault_flag_reg;
    assign result.fault_kind    = fault_code_reg;
    assign result.active_dir    = direction_reg;
    assign result.limit_reached = reached_flag_reg;

    `LSS_ASSERT_NOW(a_fault_has_kind, fault_flag_reg, fault_code_reg != FK_NONE)
    `LSS_ASSERT_NOW(a_reached_has_dir, reached_flag_reg, direction_reg != DIR_NONE)
    `LSS_ASSERT_NOW(a_fault_needs_ticks, fault_flag_reg, fault_ticks_reg != '0)
    `LSS_ASSERT_NEXT(a_state_holds_on_stall, !advance,
                     $stable(direction_reg) && $stable(fault_ticks_reg))

endmodule
